FILE: hw/rtl/assert_macros.svh
// assertion macros included by the slave engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define MRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/mrs_pkg.sv
// constants, types and the crc step for the modbus rtu slave
`default_nettype none
package mrs_pkg;

	// frame store geometry
	localparam int FRAME_BYTES = 256;
	localparam int FRAME_AW    = $clog2(FRAME_BYTES);
	localparam int LEN_W       = FRAME_AW + 1;

	// holding register file, a power of two so indices wrap by truncation
	localparam int REG_WORDS = 256;
	localparam int REG_AW    = $clog2(REG_WORDS);

	// reply position counter
	localparam int POS_W = 10;

	// crc-16 constants
	localparam logic [15:0] CRC_INIT = 16'hffff;
	localparam logic [15:0] CRC_POLY = 16'ha001;

	// function codes
	localparam logic [7:0] FC_READ   = 8'h03;
	localparam logic [7:0] FC_WRITE1 = 8'h06;
	localparam logic [7:0] FC_WRITEN = 8'h10;
	localparam logic [7:0] EXC_FLAG  = 8'h80;
	localparam logic [7:0] EXC_CODE  = 8'h01;

	// input operation codes
	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_END  = 2'd1,
		OP_PULL = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// reply kinds
	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_ECHO   = 2'd1,
		KIND_EXCEPT = 2'd2
	} kind_t;

	// configuration register indices
	localparam logic CFG_ADDR = 1'b0;
	localparam logic CFG_CRC  = 1'b1;

	// one byte through the reflected crc-16, bit by bit
	function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) r = (r >> 1) ^ CRC_POLY;
			else      r = r >> 1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mrs_ram.sv
// simple dual-port ram with registered read data
`default_nettype none
module mrs_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// read port, registered, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/modbus_rtu_slave_engine.sv
// modbus rtu slave engine top level: frame store, register file and sequencer
// Modbus RTU slave answering function codes 03, 06 and 16 (others get exception 1).
// Each input transfer carries an op in tuser (0 byte, 1 frame end, 2 pull) and a
// byte in tdata. After reset the holding register memory is cleared, during
// which no input is taken. A frame end is ignored when the frame fails the
// up-front checks; otherwise the CRC walk, when enabled, reads the frame
// memory one byte a cycle and then compares (a mismatch drops the frame),
// followed by dispatch and finish, and an FC16 write adds, per register, two
// frame memory reads and one register file write. A pull reads the register
// file, then does the byte and CRC step, and gives one output transfer while a
// reply is pending; that step waits while the output register still holds an
// unaccepted byte, and the output register lets the next item be taken while
// that byte waits.
`default_nettype none
`include "assert_macros.svh"
module modbus_rtu_slave_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input stream
	input  wire logic       s_axis_tvalid,
	output      logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] rx_byte
	input  wire logic [1:0] s_axis_tuser,  // [1:0] op
	// output stream
	output      logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output      logic [7:0] m_axis_tdata,  // [7:0] tx_byte
	output      logic       m_axis_tlast,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CRC_RUN, S_CRC_CMP, S_DISPATCH,
		S_W16_HI, S_W16_LO, S_W16_WR, S_FINISH, S_PULL_RD, S_PULL_OUT
	} state_t;

	state_t                         state_q;
	logic [7:0]                     slave_addr_q;
	logic                           crc_en_q;
	logic [mrs_pkg::LEN_W-1:0]      flen_q;
	logic                           ovr_q;
	logic [mrs_pkg::LEN_W-1:0]      blen_q;
	logic [7:0]                     hdr_q [6];
	logic [mrs_pkg::LEN_W-1:0]      idx_q;
	logic [mrs_pkg::LEN_W-1:0]      tag_s1;
	logic                           tagv_s1;
	logic [15:0]                    crc_q;
	logic [15:0]                    got_q;
	logic [7:0]                     wi_q;
	logic [7:0]                     hi_q;
	logic [mrs_pkg::REG_AW-1:0]     clr_q;
	logic                           pend_q;
	mrs_pkg::kind_t                 kind_q;
	logic [mrs_pkg::POS_W-1:0]      pos_q;
	logic [15:0]                    rcrc_q;
	logic                           out_valid_q;
	logic [7:0]                     out_data_q;
	logic                           out_last_q;

	logic                           in_fire;
	mrs_pkg::op_t                   op;
	logic                           fr_we;
	logic [mrs_pkg::FRAME_AW-1:0]   fr_waddr;
	logic                           fr_re;
	logic [mrs_pkg::FRAME_AW-1:0]   fr_raddr;
	logic [7:0]                     fr_rdata;
	logic                           hr_we;
	logic [mrs_pkg::REG_AW-1:0]     hr_waddr;
	logic [15:0]                    hr_wdata;
	logic                           hr_re;
	logic [mrs_pkg::REG_AW-1:0]     hr_raddr;
	logic [15:0]                    hr_rdata;
	logic [9:0]                     need;
	logic                           frame_ok;
	logic [9:0]                     w16_off;
	logic [mrs_pkg::POS_W-1:0]      dlen;
	logic [mrs_pkg::POS_W-1:0]      off;
	logic [7:0]                     data_byte;
	logic                           out_free;

	assign op            = mrs_pkg::op_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	// up-front frame checks: overrun, length, address and per-code minimum length
	always_comb begin
		if (hdr_q[1] == mrs_pkg::FC_READ || hdr_q[1] == mrs_pkg::FC_WRITE1)
			need = 10'd8;
		else if (hdr_q[1] == mrs_pkg::FC_WRITEN)
			need = (blen_q >= mrs_pkg::LEN_W'(6))
				? 10'd9 + {1'b0, hdr_q[5], 1'b0} : 10'd9;
		else
			need = 10'd4;
		frame_ok = !ovr_q && (blen_q >= mrs_pkg::LEN_W'(4)) && (hdr_q[0] == slave_addr_q)
			&& ((blen_q >= mrs_pkg::LEN_W'(6)) || hdr_q[1] != mrs_pkg::FC_WRITEN)
			&& (10'(blen_q) >= need);
	end

	// frame memory ports
	assign w16_off  = {1'b0, wi_q, 1'b0};
	assign fr_we    = in_fire && op == mrs_pkg::OP_BYTE
		&& blen_q < mrs_pkg::LEN_W'(mrs_pkg::FRAME_BYTES);
	assign fr_waddr = blen_q[mrs_pkg::FRAME_AW-1:0];
	always_comb begin
		fr_re    = 1'b1;
		unique case (state_q)
			S_W16_HI: fr_raddr = mrs_pkg::FRAME_AW'(w16_off + 10'd7);
			S_W16_LO: fr_raddr = mrs_pkg::FRAME_AW'(w16_off + 10'd8);
			default:  fr_raddr = idx_q[mrs_pkg::FRAME_AW-1:0];
		endcase
	end

	mrs_ram #(.DW(8), .DEPTH(mrs_pkg::FRAME_BYTES)) u_frame_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (s_axis_tdata),
		.re    (fr_re),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	// register file ports: clearing pass, fc06 and fc16 writes, pull reads
	assign off = pos_q - mrs_pkg::POS_W'(3);
	always_comb begin
		hr_we    = 1'b0;
		hr_waddr = clr_q;
		hr_wdata = 16'h0000;
		unique case (state_q)
			S_CLEAR: hr_we = 1'b1;
			S_DISPATCH: begin
				hr_we    = (hdr_q[1] == mrs_pkg::FC_WRITE1);
				hr_waddr = hdr_q[3][mrs_pkg::REG_AW-1:0];
				hr_wdata = {hdr_q[4], hdr_q[5]};
			end
			S_W16_WR: begin
				hr_we    = 1'b1;
				hr_waddr = mrs_pkg::REG_AW'(hdr_q[3] + wi_q);
				hr_wdata = {hi_q, fr_rdata};
			end
			default: hr_we = 1'b0;
		endcase
	end
	assign hr_re    = (state_q == S_PULL_RD);
	assign hr_raddr = mrs_pkg::REG_AW'(hdr_q[3] + off[8:1]);

	mrs_ram #(.DW(16), .DEPTH(mrs_pkg::REG_WORDS)) u_reg_ram (
		.clk   (clk),
		.we    (hr_we),
		.waddr (hr_waddr),
		.wdata (hr_wdata),
		.re    (hr_re),
		.raddr (hr_raddr),
		.rdata (hr_rdata)
	);

	// reply data length and the data byte at the current position
	always_comb begin
		case (kind_q)
			mrs_pkg::KIND_READ: dlen = {1'b0, hdr_q[5], 1'b0} + mrs_pkg::POS_W'(3);
			mrs_pkg::KIND_ECHO: dlen = mrs_pkg::POS_W'(6);
			default:            dlen = mrs_pkg::POS_W'(3);
		endcase
		case (kind_q)
			mrs_pkg::KIND_READ: begin
				if (pos_q == '0)                      data_byte = hdr_q[0];
				else if (pos_q == mrs_pkg::POS_W'(1)) data_byte = hdr_q[1];
				else if (pos_q == mrs_pkg::POS_W'(2)) data_byte = {hdr_q[5][6:0], 1'b0};
				else if (off[0])                      data_byte = hr_rdata[7:0];
				else                                  data_byte = hr_rdata[15:8];
			end
			mrs_pkg::KIND_ECHO: begin
				data_byte = (pos_q < mrs_pkg::POS_W'(6)) ? hdr_q[pos_q[2:0]] : 8'h00;
			end
			default: begin
				if (pos_q == '0)                      data_byte = hdr_q[0];
				else if (pos_q == mrs_pkg::POS_W'(1)) data_byte = hdr_q[1] + mrs_pkg::EXC_FLAG;
				else                                  data_byte = mrs_pkg::EXC_CODE;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'h01;
			crc_en_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrs_pkg::CFG_ADDR: slave_addr_q <= cfg_data;
				mrs_pkg::CFG_CRC:  crc_en_q     <= cfg_data[0];
				default:           crc_en_q     <= crc_en_q;
			endcase
		end
	end

	// header copy of frame bytes 0..5, written as they arrive
	always_ff @(posedge clk) begin
		if (in_fire && op == mrs_pkg::OP_BYTE && blen_q < mrs_pkg::LEN_W'(6))
			hdr_q[blen_q[2:0]] <= s_axis_tdata;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			blen_q      <= '0;
			ovr_q       <= 1'b0;
			flen_q      <= '0;
			idx_q       <= '0;
			tag_s1      <= '0;
			tagv_s1     <= 1'b0;
			crc_q       <= mrs_pkg::CRC_INIT;
			got_q       <= '0;
			wi_q        <= '0;
			hi_q        <= '0;
			pend_q      <= 1'b0;
			kind_q      <= mrs_pkg::KIND_READ;
			pos_q       <= '0;
			rcrc_q      <= mrs_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// output register empties on its transfer unless refilled below
			if (out_valid_q && m_axis_tready && !(state_q == S_PULL_OUT))
				out_valid_q <= 1'b0;
			unique case (state_q)
				// register file clearing pass
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == mrs_pkg::REG_AW'(mrs_pkg::REG_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_fire) begin
						case (op)
							mrs_pkg::OP_BYTE: begin
								pend_q <= 1'b0;
								if (blen_q < mrs_pkg::LEN_W'(mrs_pkg::FRAME_BYTES))
									blen_q <= blen_q + 1'b1;
								else
									ovr_q <= 1'b1;
							end
							mrs_pkg::OP_END: begin
								blen_q <= '0;
								ovr_q  <= 1'b0;
								flen_q <= blen_q;
								if (frame_ok) begin
									idx_q   <= '0;
									tagv_s1 <= 1'b0;
									crc_q   <= mrs_pkg::CRC_INIT;
									state_q <= crc_en_q ? S_CRC_RUN : S_DISPATCH;
								end
							end
							mrs_pkg::OP_PULL: begin
								if (pend_q) state_q <= S_PULL_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// walk the frame: crc over the body, capture the trailing crc bytes
				S_CRC_RUN: begin
					if (idx_q < flen_q) begin
						tag_s1  <= idx_q;
						tagv_s1 <= 1'b1;
						idx_q   <= idx_q + 1'b1;
					end else begin
						tagv_s1 <= 1'b0;
					end
					if (tagv_s1) begin
						if (tag_s1 < flen_q - mrs_pkg::LEN_W'(2))
							crc_q <= mrs_pkg::crc_add(crc_q, fr_rdata);
						else if (tag_s1 == flen_q - mrs_pkg::LEN_W'(2))
							got_q[7:0] <= fr_rdata;
						else begin
							got_q[15:8] <= fr_rdata;
							state_q     <= S_CRC_CMP;
						end
					end
				end
				S_CRC_CMP: begin
					state_q <= (crc_q == got_q) ? S_DISPATCH : S_IDLE;
				end
				// frame accepted: pick the reply and start any register writes
				S_DISPATCH: begin
					pend_q <= 1'b0;
					wi_q   <= '0;
					if (hdr_q[1] == mrs_pkg::FC_READ) begin
						kind_q  <= mrs_pkg::KIND_READ;
						state_q <= S_FINISH;
					end else if (hdr_q[1] == mrs_pkg::FC_WRITE1) begin
						kind_q  <= mrs_pkg::KIND_ECHO;
						state_q <= S_FINISH;
					end else if (hdr_q[1] == mrs_pkg::FC_WRITEN) begin
						kind_q  <= mrs_pkg::KIND_ECHO;
						state_q <= (hdr_q[5] == 8'h00) ? S_FINISH : S_W16_HI;
					end else begin
						kind_q  <= mrs_pkg::KIND_EXCEPT;
						state_q <= S_FINISH;
					end
				end
				S_W16_HI: state_q <= S_W16_LO;
				S_W16_LO: begin
					hi_q    <= fr_rdata;
					state_q <= S_W16_WR;
				end
				S_W16_WR: begin
					wi_q <= wi_q + 1'b1;
					state_q <= (wi_q + 1'b1 == hdr_q[5]) ? S_FINISH : S_W16_HI;
				end
				S_FINISH: begin
					pend_q  <= 1'b1;
					pos_q   <= '0;
					rcrc_q  <= mrs_pkg::CRC_INIT;
					state_q <= S_IDLE;
				end
				S_PULL_RD: state_q <= S_PULL_OUT;
				// emit one reply byte once the output register is free
				S_PULL_OUT: begin
					out_valid_q <= !out_free || (out_valid_q && !m_axis_tready) || out_free;
					if (out_free) begin
						state_q     <= S_IDLE;
						if (pos_q < dlen) begin
							out_data_q <= data_byte;
							out_last_q <= 1'b0;
							rcrc_q     <= mrs_pkg::crc_add(rcrc_q, data_byte);
							pos_q      <= pos_q + 1'b1;
						end else if (pos_q == dlen) begin
							out_data_q <= rcrc_q[7:0];
							out_last_q <= 1'b0;
							pos_q      <= pos_q + 1'b1;
						end else begin
							out_data_q <= rcrc_q[15:8];
							out_last_q <= 1'b1;
							pend_q     <= 1'b0;
							pos_q      <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the final crc byte ends the reply
	`MRS_ASSERT_NXT(a_last_clears, state_q == S_PULL_OUT && out_free && pos_q > dlen, !pend_q)
	// register file is never written while a reply byte is being read
	`MRS_ASSERT_IMP(a_no_wr_in_pull, state_q == S_PULL_RD || state_q == S_PULL_OUT, !hr_we)
	// crc walk never looks past the frame
	`MRS_ASSERT_IMP(a_tag_in_frame, state_q == S_CRC_RUN && tagv_s1, tag_s1 < flen_q)
	// a pull only starts with a reply pending
	`MRS_ASSERT_NXT(a_pull_pending, in_fire && op == mrs_pkg::OP_PULL && !pend_q, state_q == S_IDLE)

endmodule
`default_nettype wire
